[hdl/sfd_pkg.sv]
package sfd_pkg;

	localparam int N_ENTRIES = 32;
	localparam int IDX_W = $clog2(N_ENTRIES);
	localparam int N_ILI = 32;
	localparam int N_ISI = 12;

	localparam logic [7:0] BOARD_ILI = 8'd4;
	localparam logic [7:0] BOARD_ISI = 8'd6;
	localparam logic [7:0] BOARD_MICRO = 8'd8;

	localparam logic [5:0] CODE_NO_FAULT = 6'd0;
	localparam logic [5:0] CODE_COMM_FAIL = 6'd1;
	localparam logic [5:0] CODE_ILI_BASE = 6'd2;
	localparam logic [5:0] CODE_ISI_BASE = 6'd34;

	typedef enum logic [0:0] {
		REG_BOARD_ID = 1'b0,
		REG_BYPASS   = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [23:0] fault_word_a;
		logic [23:0] fault_word_b;
		logic        read_timed_out;
	} in_item_t;

	typedef struct packed {
		logic [5:0] fault_code;
		logic       is_hard;
	} out_item_t;

	// one decode entry: which word, which bit (active low), bypass bits
	typedef struct packed {
		logic       sel_b;
		logic [4:0] bit_pos;
		logic [7:0] bypass;
	} entry_t;

	localparam entry_t ILI_TAB [N_ILI] = '{
		'{1'b0, 5'd0, 8'd1},    '{1'b0, 5'd1, 8'd1},    '{1'b0, 5'd2, 8'd1},
		'{1'b0, 5'd3, 8'd8},    '{1'b0, 5'd4, 8'd8},    '{1'b0, 5'd5, 8'd8},
		'{1'b0, 5'd6, 8'd8},    '{1'b0, 5'd7, 8'd8},
		'{1'b0, 5'd8, 8'd16},   '{1'b0, 5'd9, 8'd16},   '{1'b0, 5'd10, 8'd16},
		'{1'b0, 5'd11, 8'd128}, '{1'b0, 5'd12, 8'd128}, '{1'b0, 5'd13, 8'd128},
		'{1'b0, 5'd14, 8'd128}, '{1'b0, 5'd15, 8'd128},
		'{1'b0, 5'd16, 8'd0},   '{1'b0, 5'd17, 8'd0},   '{1'b0, 5'd18, 8'd0},
		'{1'b0, 5'd19, 8'd0},   '{1'b0, 5'd20, 8'd0},   '{1'b0, 5'd21, 8'd0},
		'{1'b0, 5'd22, 8'd0},   '{1'b0, 5'd23, 8'd0},
		'{1'b1, 5'd0, 8'd17},   '{1'b1, 5'd1, 8'd17},   '{1'b1, 5'd2, 8'd17},
		'{1'b1, 5'd3, 8'd0},    '{1'b1, 5'd4, 8'd0},    '{1'b1, 5'd5, 8'd32},
		'{1'b1, 5'd6, 8'd0},    '{1'b1, 5'd7, 8'd0}
	};

	localparam entry_t ISI_TAB [N_ISI] = '{
		'{1'b0, 5'd6, 8'd0},  '{1'b0, 5'd14, 8'd0}, '{1'b0, 5'd22, 8'd0},
		'{1'b0, 5'd4, 8'd0},  '{1'b0, 5'd5, 8'd0},
		'{1'b1, 5'd1, 8'd0},  '{1'b1, 5'd3, 8'd0},  '{1'b1, 5'd4, 8'd0},
		'{1'b1, 5'd5, 8'd0},  '{1'b1, 5'd6, 8'd0},  '{1'b1, 5'd7, 8'd0},
		'{1'b1, 5'd0, 8'd0}
	};

	typedef struct packed {
		logic load;
		logic step;
		logic clear;
	} ctl_cmd_t;

	typedef struct packed {
		logic rem_empty;
		logic cur_set;
		logic last;
	} dp_status_t;

endpackage

[hdl/safety_fault_decoder.sv]
// an accepted item is loaded into a pending vector, then the scan walks the table slots
//   up to the last pending one (32 ili slots, 12 isi slots); no new item is taken until
//   the scan is done and the block is back in idle
// results leave at most one per cycle; the scan steps over a slot with nothing pending
//   and a stall holds the scan
// reset: arst_n low clears board_id and bypass_mask to 0 and returns the block to idle

module safety_fault_decoder (
	input  logic               clk,
	input  logic               arst_n,
	// configuration: 0 board_id, 1 bypass_mask
	input  logic               cfg_we,
	input  logic [0:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	// input item channel
	input  logic               in_valid,
	output logic               in_ready,
	input  sfd_pkg::in_item_t  in_item,
	// result item channel
	output logic               out_valid,
	input  logic               out_ready,
	output sfd_pkg::out_item_t out_item
);

	// commands from controller, status back from datapath
	sfd_pkg::ctl_cmd_t   cmd;
	sfd_pkg::dp_status_t status;

	// controller: idle accepts one item, scan walks pending entries and
	// presents a result whenever the current slot is pending
	sfd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// datapath: config registers, table decode on load into a pending
	// vector, scan index and result formatting
	// timeout, illegal board and no active entry all load one pending slot
	// with a fixed code so they take the same emission path
	sfd_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_item   (in_item),
		.cmd       (cmd),
		.status    (status),
		.out_item  (out_item)
	);

endmodule

[hdl/sfd_datapath.sv]
module sfd_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [0:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	input  sfd_pkg::in_item_t   in_item,
	input  sfd_pkg::ctl_cmd_t   cmd,
	output sfd_pkg::dp_status_t status,
	output sfd_pkg::out_item_t  out_item
);

	logic [7:0] board_id_q;
	// table bypass bits only reach the low byte of the mask
	logic [7:0] bypass_q;

	logic [sfd_pkg::N_ENTRIES-1:0]   rem_q;
	logic [sfd_pkg::IDX_W-1:0]       idx_q;
	logic                            ili_q;
	logic                            single_q;
	logic [5:0]                      single_code_q;

	logic                            is_ili;
	logic                            is_isi;
	logic                            comm_fail;
	logic [sfd_pkg::N_ENTRIES-1:0]   act;
	logic [sfd_pkg::N_ENTRIES-1:0]   byp;
	logic [sfd_pkg::N_ENTRIES-1:0]   cur_onehot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			board_id_q <= '0;
			bypass_q   <= '0;
		end else if (cfg_we) begin
			unique case (sfd_pkg::cfg_reg_t'(cfg_index))
				sfd_pkg::REG_BOARD_ID: board_id_q <= cfg_data[7:0];
				sfd_pkg::REG_BYPASS:   bypass_q   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign is_ili = (board_id_q == sfd_pkg::BOARD_ILI);
	assign is_isi = (board_id_q == sfd_pkg::BOARD_ISI) || (board_id_q == sfd_pkg::BOARD_MICRO);
	assign comm_fail = in_item.read_timed_out || !(is_ili || is_isi);

	// per-entry active and bypass flags for the selected table
	always_comb begin
		sfd_pkg::entry_t e;
		act = '0;
		byp = '0;
		e = '0;
		for (int i = 0; i < sfd_pkg::N_ENTRIES; i++) begin
			if (is_ili) begin
				e = sfd_pkg::ILI_TAB[i];
				act[i] = e.sel_b ? ~in_item.fault_word_b[e.bit_pos]
				                 : ~in_item.fault_word_a[e.bit_pos];
				byp[i] = |(e.bypass & bypass_q);
			end else if (i < sfd_pkg::N_ISI) begin
				e = sfd_pkg::ISI_TAB[i];
				act[i] = e.sel_b ? ~in_item.fault_word_b[e.bit_pos]
				                 : ~in_item.fault_word_a[e.bit_pos];
				byp[i] = |(e.bypass & bypass_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q    <= '0;
			idx_q    <= '0;
			single_q <= 1'b0;
			ili_q    <= 1'b0;
		end else if (cmd.load) begin
			idx_q <= '0;
			ili_q <= is_ili;
			if (comm_fail || act == '0) begin
				single_q <= 1'b1;
				rem_q    <= sfd_pkg::N_ENTRIES'(1);
			end else begin
				single_q <= 1'b0;
				rem_q    <= act & ~byp;
			end
		end else if (cmd.clear) begin
			rem_q <= rem_q & ~cur_onehot;
			idx_q <= idx_q + 1'b1;
		end else if (cmd.step) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			single_code_q <= comm_fail ? sfd_pkg::CODE_COMM_FAIL : sfd_pkg::CODE_NO_FAULT;
		end
	end

	assign cur_onehot = sfd_pkg::N_ENTRIES'(1) << idx_q;

	assign status.rem_empty = (rem_q == '0);
	assign status.cur_set   = rem_q[idx_q];
	assign status.last      = single_q || ((rem_q & ~cur_onehot) == '0);

	always_comb begin
		if (single_q) begin
			out_item.fault_code = single_code_q;
		end else if (ili_q) begin
			out_item.fault_code = sfd_pkg::CODE_ILI_BASE + 6'(idx_q);
		end else begin
			out_item.fault_code = sfd_pkg::CODE_ISI_BASE + 6'(idx_q);
		end
		out_item.is_hard = status.last;
	end

`ifndef SYNTH
	a_load_idx: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> idx_q == '0)
		else $error("scan index not restarted on load");
	a_single_one: assert property (@(posedge clk) disable iff (!arst_n)
		single_q |-> $countones(rem_q) <= 1)
		else $error("single result run holds more than one pending entry");
	a_clear_bit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear && !cmd.load |=> !rem_q[$past(idx_q)])
		else $error("emitted entry still pending");
`endif

endmodule

[hdl/sfd_ctrl.sv]
module sfd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  sfd_pkg::dp_status_t status,
	output sfd_pkg::ctl_cmd_t   cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_SCAN) && status.cur_set;

	assign cmd.load  = in_valid && in_ready;
	assign cmd.clear = out_valid && out_ready;
	assign cmd.step  = (state_q == ST_SCAN) && !status.rem_empty && !status.cur_set;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.load) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (status.rem_empty || (cmd.clear && status.last)) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTH
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while a result is pending");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear && status.last |=> in_ready)
		else $error("not idle after hard result");
	a_empty_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) && status.rem_empty |=> state_q == ST_IDLE)
		else $error("scan continued with nothing pending");
`endif

endmodule

[bench/safety_fault_decoder_tb.sv]
module safety_fault_decoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// cycles with no item moving on either channel before the run is abandoned
	localparam int IDLE_LIMIT = 20000;
	// quiet cycles (receiver ready) allowed for a scan that emits nothing
	localparam int SCAN_SETTLE = 40;
	localparam int N_PHASES = 10;
	localparam int PHASE_ITEMS = 50;

	// bypass bits of the ili entries, register 0 slots then register 1 slots
	localparam logic [7:0] ILI_BYPASS [32] = '{
		8'd1, 8'd1, 8'd1, 8'd8, 8'd8, 8'd8, 8'd8, 8'd8,
		8'd16, 8'd16, 8'd16, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128,
		8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
		8'd17, 8'd17, 8'd17, 8'd0, 8'd0, 8'd32, 8'd0, 8'd0
	};
	// isi / micro entries: first five watch register 0, the rest register 1
	localparam int ISI_REG0_SLOTS = 5;
	localparam int ISI_BIT [12] = '{6, 14, 22, 4, 5, 1, 3, 4, 5, 6, 7, 0};

	// one directed row: register settings, status words and an optional known answer
	typedef struct packed {
		logic [15:0] board_word;
		logic [15:0] bypass;
		logic [23:0] word_a;
		logic [23:0] word_b;
		logic        timed_out;
		logic        known;
		logic [5:0]  known_code;
	} status_row_t;

	localparam int N_ROWS = 25;
	localparam status_row_t STATUS_ROWS [N_ROWS] = '{
		// reset settings: board 0 is not a legal board
		'{16'h0000, 16'h0000, 24'h000000, 24'h000000, 1'b0, 1'b1, sfd_pkg::CODE_COMM_FAIL},
		'{16'h0000, 16'h0000, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b1, sfd_pkg::CODE_COMM_FAIL},
		// ili: nothing active, everything active, timeout
		'{16'h0004, 16'h0000, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 1'b1, sfd_pkg::CODE_NO_FAULT},
		'{16'h0004, 16'h0000, 24'h000000, 24'h000000, 1'b0, 1'b0, sfd_pkg::CODE_NO_FAULT},
		'{16'h0004, 16'h0000, 24'h000000, 24'h000000, 1'b1, 1'b1, sfd_pkg::CODE_COMM_FAIL},
		// first and last ili entry alone
		'{16'h0004, 16'h0000, 24'hFFFFFE, 24'hFFFFFF, 1'b0, 1'b0, sfd_pkg::CODE_NO_FAULT},
		'{16'h0004, 16'h0000, 24'hFFFFFF, 24'hFFFF7F, 1'b0, 1'b0, sfd_pkg::CODE_NO_FAULT},
		// full bypass: only entries without bypass bits survive
		'{16'h0004, 16'hFFFF, 24'h000000, 24'h000000, 1'b0, 1'b0, sfd_pkg::CODE_NO_FAULT},
		// every active entry bypassed: no item comes out
		'{16'h0004, 16'h00B9, 24'hFF0000, 24'hFFFFD8, 1'b0, 1'b0, sfd_pkg::CODE_NO_FAULT},
		// bypass bits that no entry uses, then a partial ili bypass
		'{16'h0004, 16'hFF00, 24'h000000, 24'h000000, 1'b0, 1'b0, sfd_pkg::CODE_NO_FAULT},
		'{16'h0004, 16'h0011, 24'h000000, 24'hFFFFFF, 1'b0, 1'b0, sfd_pkg::CODE_NO_FAULT},
		// isi board
		'{16'h0006, 16'h0000, 24'h000000, 24'h000000, 1'b0, 1'b0, sfd_pkg::CODE_NO_FAULT},
		'{16'h0006, 16'h0000, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 1'b1, sfd_pkg::CODE_NO_FAULT},
		'{16'h0006, 16'hFFFF, 24'h000000, 24'h000000, 1'b0, 1'b0, sfd_pkg::CODE_NO_FAULT},
		'{16'h0006, 16'hFFFF, 24'hBFFFFF, 24'hFFFFFF, 1'b0, 1'b0, sfd_pkg::CODE_NO_FAULT},
		'{16'h0006, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFE, 1'b0, 1'b0, sfd_pkg::CODE_NO_FAULT},
		'{16'h0006, 16'hFFFF, 24'h000000, 24'h000000, 1'b1, 1'b1, sfd_pkg::CODE_COMM_FAIL},
		// micro board shares the isi tables
		'{16'h0008, 16'h0000, 24'h000000, 24'h000000, 1'b0, 1'b0, sfd_pkg::CODE_NO_FAULT},
		'{16'h0008, 16'h0000, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 1'b1, sfd_pkg::CODE_NO_FAULT},
		// zeros outside the isi table bits are not faults
		'{16'h0008, 16'h0000, 24'h404070, 24'h0000FF, 1'b0, 1'b1, sfd_pkg::CODE_NO_FAULT},
		// illegal boards
		'{16'h0005, 16'h0000, 24'h000000, 24'h000000, 1'b0, 1'b1, sfd_pkg::CODE_COMM_FAIL},
		'{16'h00FF, 16'h0000, 24'h000000, 24'h000000, 1'b0, 1'b1, sfd_pkg::CODE_COMM_FAIL},
		'{16'h0007, 16'h0000, 24'h000000, 24'h000000, 1'b0, 1'b1, sfd_pkg::CODE_COMM_FAIL},
		'{16'h0009, 16'h0000, 24'h000000, 24'h000000, 1'b0, 1'b1, sfd_pkg::CODE_COMM_FAIL},
		// upper byte of the board write is dropped
		'{16'hAB04, 16'h0000, 24'h5A5A5A, 24'hA5A5A5, 1'b0, 1'b0, sfd_pkg::CODE_NO_FAULT}
	};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [0:0]         cfg_index = sfd_pkg::REG_BOARD_ID;
	logic [15:0]        cfg_data = 16'h0000;
	logic               in_valid = 1'b0;
	logic               in_ready;
	sfd_pkg::in_item_t  in_item = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	sfd_pkg::out_item_t out_item;

	// predictor's copy of the two registers
	logic [15:0] board_word_now = 16'h0000;
	logic [15:0] bypass_now = 16'h0000;

	sfd_pkg::out_item_t pending_faults [$];
	int                 mismatches = 0;
	bit                 gap_free = 1'b0;

	safety_fault_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// fault list for one status item under the current register settings
	function automatic void predict_faults(sfd_pkg::in_item_t it);
		logic [7:0]         board;
		logic [5:0]         codes [32];
		logic               bit_val;
		int                 n_codes;
		int                 n_active;
		sfd_pkg::out_item_t r;
		board = board_word_now[7:0];
		n_codes = 0;
		n_active = 0;
		// timeout or illegal board: one communication failure, nothing scanned
		if (it.read_timed_out || !(board == sfd_pkg::BOARD_ILI ||
				board == sfd_pkg::BOARD_ISI || board == sfd_pkg::BOARD_MICRO)) begin
			r.fault_code = sfd_pkg::CODE_COMM_FAIL;
			r.is_hard = 1'b1;
			pending_faults.push_back(r);
			return;
		end
		if (board == sfd_pkg::BOARD_ILI) begin
			for (int k = 0; k < 32; k++) begin
				bit_val = (k < 24) ? it.fault_word_a[k] : it.fault_word_b[k - 24];
				if (!bit_val) begin
					n_active++;
					// entries without bypass bits can never be suppressed
					if ((ILI_BYPASS[k] & bypass_now[7:0]) == 8'd0) begin
						codes[n_codes] = sfd_pkg::CODE_ILI_BASE + 6'(k);
						n_codes++;
					end
				end
			end
		end else begin
			for (int k = 0; k < 12; k++) begin
				bit_val = (k < ISI_REG0_SLOTS) ? it.fault_word_a[ISI_BIT[k]] :
					it.fault_word_b[ISI_BIT[k]];
				if (!bit_val) begin
					n_active++;
					codes[n_codes] = sfd_pkg::CODE_ISI_BASE + 6'(k);
					n_codes++;
				end
			end
		end
		if (n_active == 0) begin
			r.fault_code = sfd_pkg::CODE_NO_FAULT;
			r.is_hard = 1'b1;
			pending_faults.push_back(r);
			return;
		end
		// all active bypassed leaves n_codes at zero: nothing expected
		for (int k = 0; k < n_codes; k++) begin
			r.fault_code = codes[k];
			r.is_hard = (k == n_codes - 1);
			pending_faults.push_back(r);
		end
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		if (gap_free)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(30, 80);
	endfunction

	function automatic sfd_pkg::in_item_t random_status();
		sfd_pkg::in_item_t it;
		logic [23:0]       wa;
		logic [23:0]       wb;
		int                mode;
		mode = $urandom_range(0, 9);
		wa = 24'($urandom());
		wb = 24'($urandom());
		case (mode)
			1: begin
				wa = 24'hFFFFFF;
				wb = 24'hFFFFFF;
			end
			4, 5, 6: begin
				// a few faults on an otherwise healthy board
				wa = 24'hFFFFFF;
				wb = 24'hFFFFFF;
				repeat ($urandom_range(0, 3)) wa[$urandom_range(0, 23)] = 1'b0;
				repeat ($urandom_range(0, 2)) wb[$urandom_range(0, 7)] = 1'b0;
			end
			7: begin
				wa = wa & 24'($urandom()) & 24'($urandom());
				wb = wb & 24'($urandom());
			end
			8: begin
				wa = 24'h000000;
				wb = 24'h000000;
			end
			9: begin
				if ($urandom_range(0, 1))
					wa = 24'hFFFFFF;
				else
					wb = 24'hFFFFFF;
			end
			default: ;
		endcase
		it.fault_word_a = wa;
		it.fault_word_b = wb;
		it.read_timed_out = (mode == 0) || ($urandom_range(0, 19) == 0);
		return it;
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic offer_status(sfd_pkg::in_item_t it, int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_item <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_faults(it);
		@(negedge clk);
	endtask

	// wait for every expected item, then let a silent scan run out
	task automatic settle();
		int quiet;
		in_valid <= 1'b0;
		while (pending_faults.size() != 0) @(posedge clk);
		quiet = 0;
		while (quiet < SCAN_SETTLE) begin
			@(posedge clk);
			if (out_ready)
				quiet++;
		end
		@(negedge clk);
	endtask

	// both registers on back-to-back cycles, only while the block is idle
	task automatic write_settings(logic [15:0] board_word, logic [15:0] bypass);
		cfg_we <= 1'b1;
		cfg_index <= sfd_pkg::REG_BOARD_ID;
		cfg_data <= board_word;
		@(negedge clk);
		cfg_index <= sfd_pkg::REG_BYPASS;
		cfg_data <= bypass;
		@(negedge clk);
		cfg_we <= 1'b0;
		board_word_now = board_word;
		bypass_now = bypass;
	endtask

	// result side: check every accepted item against the oldest expectation
	always @(posedge clk) begin
		sfd_pkg::out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_faults.size() == 0) begin
				$display("%0t: unexpected item, fault_code %0d is_hard %0d",
					$time, out_item.fault_code, out_item.is_hard);
				mismatches++;
			end else begin
				want = pending_faults.pop_front();
				if (out_item.fault_code !== want.fault_code) begin
					$display("%0t: fault_code expected %0d got %0d",
						$time, want.fault_code, out_item.fault_code);
					mismatches++;
				end
				if (out_item.is_hard !== want.is_hard) begin
					$display("%0t: is_hard expected %0d got %0d",
						$time, want.is_hard, out_item.is_hard);
					mismatches++;
				end
			end
		end
	end

	// receiver ready: bursts of readiness broken by stalls, mostly short
	initial begin
		int burst;
		int stall;
		int r;
		burst = 0;
		stall = 0;
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else if (burst > 0) begin
				out_ready <= 1'b1;
				burst--;
			end else begin
				out_ready <= 1'b1;
				burst = $urandom_range(0, 40);
				r = $urandom_range(0, 99);
				if (r < 30)
					stall = 0;
				else if (r < 75)
					stall = $urandom_range(1, 3);
				else if (r < 95)
					stall = $urandom_range(4, 10);
				else
					stall = $urandom_range(20, 60);
			end
		end
	end

	// watchdog: give up when no item moves for too long
	initial begin
		int idle;
		idle = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle = 0;
			else
				idle++;
			if (idle >= IDLE_LIMIT) begin
				$display("%0t: no item moved for %0d cycles", $time, idle);
				$display("safety_fault_decoder_tb NOT OK");
				$finish;
			end
		end
	end

	initial begin
		sfd_pkg::in_item_t  it;
		status_row_t        row;
		sfd_pkg::out_item_t known_fault;
		logic [15:0]        board_word;
		logic [15:0]        bypass;
		int                 pick;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed rows; the first ones run on the reset settings
		for (int i = 0; i < N_ROWS; i++) begin
			row = STATUS_ROWS[i];
			if (row.board_word != board_word_now || row.bypass != bypass_now) begin
				settle();
				write_settings(row.board_word, row.bypass);
			end
			it.fault_word_a = row.word_a;
			it.fault_word_b = row.word_b;
			it.read_timed_out = row.timed_out;
			if (row.known) begin
				// known single answer stands in for the prediction
				offer_status(it, pick_gap());
				while (pending_faults.size() != 0)
					void'(pending_faults.pop_back());
				known_fault.fault_code = row.known_code;
				known_fault.is_hard = 1'b1;
				pending_faults.push_back(known_fault);
			end else begin
				offer_status(it, pick_gap());
			end
		end

		// random phases, each under new register settings
		for (int p = 0; p < N_PHASES; p++) begin
			settle();
			pick = $urandom_range(0, 9);
			board_word = {8'($urandom()), 8'h00};
			if (pick < 4)
				board_word[7:0] = sfd_pkg::BOARD_ILI;
			else if (pick < 6)
				board_word[7:0] = sfd_pkg::BOARD_ISI;
			else if (pick < 8)
				board_word[7:0] = sfd_pkg::BOARD_MICRO;
			else
				board_word[7:0] = 8'($urandom());
			case ($urandom_range(0, 4))
				0: bypass = 16'h0000;
				1: bypass = 16'hFFFF;
				2: bypass = 16'($urandom());
				3: bypass = {8'($urandom()), 8'($urandom()) & 8'hB9};
				default: bypass = 16'h0001 << $urandom_range(0, 15);
			endcase
			write_settings(board_word, bypass);
			// every fourth phase runs back to back
			gap_free = (p % 4 == 1);
			for (int i = 0; i < PHASE_ITEMS; i++)
				offer_status(random_status(), pick_gap());
		end
		gap_free = 1'b0;

		settle();
		if (mismatches == 0)
			$display("safety_fault_decoder_tb OK");
		else
			$display("safety_fault_decoder_tb NOT OK");
		$finish;
	end

endmodule
